### sv/rdcw_pkg.sv
`timescale 1ns / 1ps

package rdcw_pkg;

    localparam int POS_W = 10;
    localparam int CNT_W = 11;
    localparam int OP_W = 2;
    localparam int PTR_W = 12;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 16;

    localparam int DEF_ARRAY_DEPTH = 1024;
    localparam int DEF_VALUE_RANGE = 1024;

    localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY   = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP     = 2'd3;

    typedef logic [2:0] move_t;

    localparam move_t MV_NONE   = 3'd0;
    localparam move_t MV_EXT_LO = 3'd1;
    localparam move_t MV_EXT_HI = 3'd2;
    localparam move_t MV_SHR_LO = 3'd3;
    localparam move_t MV_SHR_HI = 3'd4;

    typedef struct packed {
        logic capture;
        logic win_reset;
        logic clear_step;
        logic mod_step;
        logic elem_write;
        logic step_start;
        logic cnt_read;
        logic cnt_update;
        logic result_load;
    } dp_cmd_t;

    typedef struct packed {
        logic  clear_last;
        logic  bad;
        move_t move;
        logic  out_free;
    } dp_status_t;

endpackage

### sv/rdcw_datapath.sv
`timescale 1ns / 1ps

module rdcw_datapath #(
    parameter int ARRAY_DEPTH = rdcw_pkg::DEF_ARRAY_DEPTH,
    parameter int VALUE_RANGE = rdcw_pkg::DEF_VALUE_RANGE
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [rdcw_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rdcw_pkg::M_DATA_W-1:0]    m_tdata,
    output logic                             m_tuser,
    input  rdcw_pkg::dp_cmd_t                cmd,
    output rdcw_pkg::dp_status_t             st
);

    localparam int POS_W = rdcw_pkg::POS_W;
    localparam int CNT_W = rdcw_pkg::CNT_W;
    localparam int PTR_W = rdcw_pkg::PTR_W;
    // Positions and values never exceed what a 10-bit field can carry.
    localparam int SDEPTH = (ARRAY_DEPTH < (1 << POS_W)) ? ARRAY_DEPTH : (1 << POS_W);
    localparam int CDEPTH = (VALUE_RANGE < (1 << POS_W)) ? VALUE_RANGE : (1 << POS_W);
    localparam int AW = $clog2(SDEPTH);
    localparam int EW = $clog2(CDEPTH);
    // The reciprocal quotient is exact for every 10-bit value with this shift.
    localparam int RECIP_SH = 21;
    localparam int RECIP_M  = (VALUE_RANGE > (1 << POS_W)) ? 0 :
                              ((1 << RECIP_SH) + VALUE_RANGE - 1) / VALUE_RANGE;

    logic [EW-1:0]          elem_mem [SDEPTH];
    logic [CNT_W-1:0]       cnt_mem [CDEPTH];

    logic [POS_W-1:0]       in_index;
    logic [POS_W-1:0]       in_value;
    logic [POS_W-1:0]       in_left;
    logic [POS_W-1:0]       in_right;

    logic [POS_W-1:0]       index_reg;
    logic                   index_ok_reg;
    logic [POS_W-1:0]       lo_reg;
    logic [POS_W-1:0]       hi_reg;
    logic                   bad_reg;
    logic [POS_W-1:0]       val_reg;
    logic [POS_W-1:0]       quot_reg;
    logic [31:0]            recip_prod;
    logic [31:0]            quot_prod;
    logic [POS_W-1:0]       mod_res;

    logic signed [PTR_W-1:0] wl_reg;
    logic signed [PTR_W-1:0] wh_reg;
    logic signed [PTR_W-1:0] wl_next;
    logic signed [PTR_W-1:0] wh_next;
    logic signed [PTR_W-1:0] lo_s;
    logic signed [PTR_W-1:0] hi_s;
    logic signed [PTR_W-1:0] pos_sel;
    rdcw_pkg::move_t        move;
    logic                   add_reg;

    logic [EW-1:0]          clr_addr_reg;
    logic                   clear_last;
    logic [EW-1:0]          elem_q;
    logic [CNT_W-1:0]       cnt_q;
    logic [CNT_W-1:0]       cnt_new;
    logic [CNT_W-1:0]       total_reg;
    logic [CNT_W-1:0]       total_next;

    logic                   m_valid_reg;
    logic [CNT_W-1:0]       m_count_reg;
    logic                   m_status_reg;

    assign in_index = s_tdata[POS_W-1:0];
    assign in_value = s_tdata[2*POS_W-1:POS_W];
    assign in_left  = s_tdata[3*POS_W-1:2*POS_W];
    assign in_right = s_tdata[4*POS_W-1:3*POS_W];

    // Input capture; query positions saturate to the last array entry.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            index_reg    <= in_index;
            index_ok_reg <= (32'(in_index) < ARRAY_DEPTH);
            lo_reg       <= (32'(in_left) < ARRAY_DEPTH) ? in_left : POS_W'(ARRAY_DEPTH - 1);
            hi_reg       <= (32'(in_right) < ARRAY_DEPTH) ? in_right : POS_W'(ARRAY_DEPTH - 1);
            bad_reg      <= (in_left > in_right);
            val_reg      <= in_value;
        end
    end

    // Load value modulo VALUE_RANGE: the quotient is registered from a reciprocal
    // multiply, the remainder is formed when the element is written.
    assign recip_prod = 32'(val_reg) * 32'(RECIP_M);
    assign quot_prod  = 32'(quot_reg) * 32'(VALUE_RANGE);
    assign mod_res    = POS_W'(32'(val_reg) - quot_prod);

    always_ff @(posedge aclk) begin
        if (cmd.mod_step) begin
            quot_reg <= recip_prod[RECIP_SH+POS_W-1:RECIP_SH];
        end
    end

    // Window move selection follows the fixed order: grow down, grow up,
    // shrink from below, shrink from above.
    assign lo_s = $signed({{(PTR_W-POS_W){1'b0}}, lo_reg});
    assign hi_s = $signed({{(PTR_W-POS_W){1'b0}}, hi_reg});

    always_comb begin
        if (wl_reg > lo_s) begin
            move = rdcw_pkg::MV_EXT_LO;
        end else if (wh_reg < hi_s) begin
            move = rdcw_pkg::MV_EXT_HI;
        end else if (wl_reg < lo_s) begin
            move = rdcw_pkg::MV_SHR_LO;
        end else if (wh_reg > hi_s) begin
            move = rdcw_pkg::MV_SHR_HI;
        end else begin
            move = rdcw_pkg::MV_NONE;
        end
    end

    always_comb begin
        wl_next = wl_reg;
        wh_next = wh_reg;
        pos_sel = wl_reg;
        case (move)
            rdcw_pkg::MV_EXT_LO: begin
                wl_next = wl_reg - 1'b1;
                pos_sel = wl_next;
            end
            rdcw_pkg::MV_EXT_HI: begin
                wh_next = wh_reg + 1'b1;
                pos_sel = wh_next;
            end
            rdcw_pkg::MV_SHR_LO: begin
                wl_next = wl_reg + 1'b1;
                pos_sel = wl_reg;
            end
            rdcw_pkg::MV_SHR_HI: begin
                wh_next = wh_reg - 1'b1;
                pos_sel = wh_reg;
            end
            default: begin
                pos_sel = wl_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.win_reset) begin
            wl_reg <= '0;
            wh_reg <= '1;
        end else if (cmd.step_start) begin
            wl_reg <= wl_next;
            wh_reg <= wh_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step_start) begin
            add_reg <= (move == rdcw_pkg::MV_EXT_LO) || (move == rdcw_pkg::MV_EXT_HI);
        end
    end

    // Element store: one write port for loads, one registered read for steps.
    always_ff @(posedge aclk) begin
        if (cmd.elem_write && index_ok_reg) begin
            elem_mem[index_reg[AW-1:0]] <= mod_res[EW-1:0];
        end
        if (cmd.step_start) begin
            elem_q <= elem_mem[pos_sel[AW-1:0]];
        end
    end

    // Count store, swept to zero after reset and on restart.
    assign clear_last = (clr_addr_reg == EW'(CDEPTH - 1));
    assign cnt_new    = add_reg ? (cnt_q + 1'b1) : (cnt_q - 1'b1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clear_step) begin
            clr_addr_reg <= clear_last ? '0 : (clr_addr_reg + 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clear_step) begin
            cnt_mem[clr_addr_reg] <= '0;
        end else if (cmd.cnt_update) begin
            cnt_mem[elem_q] <= cnt_new;
        end
        if (cmd.cnt_read) begin
            cnt_q <= cnt_mem[elem_q];
        end
    end

    always_comb begin
        total_next = total_reg;
        if (add_reg && (cnt_q == '0)) begin
            total_next = total_reg + 1'b1;
        end else if (!add_reg && (cnt_new == '0)) begin
            total_next = total_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.win_reset) begin
            total_reg <= '0;
        end else if (cmd.cnt_update) begin
            total_reg <= total_next;
        end
    end

    // Output register lets the next item in while a result waits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.result_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.result_load) begin
            m_count_reg  <= bad_reg ? '0 : total_reg;
            m_status_reg <= bad_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(rdcw_pkg::M_DATA_W-CNT_W){1'b0}}, m_count_reg};
    assign m_tuser  = m_status_reg;

    assign st.clear_last = clear_last;
    assign st.bad        = bad_reg;
    assign st.move       = move;
    assign st.out_free   = !m_valid_reg || m_tready;

    a_window_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        (wl_reg - wh_reg) <= $signed(PTR_W'(1)))
        else $error("window low pointer passed high pointer plus one");

    a_pointer_single_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(cmd.win_reset) |->
        (wl_reg == $past(wl_reg) || wl_reg == $past(wl_reg) + 1'b1 ||
         wl_reg == $past(wl_reg) - 1'b1))
        else $error("window low pointer moved by more than one position");

    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.result_load |-> (!m_valid_reg || m_tready))
        else $error("result loaded over a pending transfer");

endmodule

### sv/rdcw_ctrl.sv
`timescale 1ns / 1ps

module rdcw_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rdcw_pkg::OP_W-1:0]     s_op,
    output rdcw_pkg::dp_cmd_t             cmd,
    input  rdcw_pkg::dp_status_t          st
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_MOD   = 4'd2;
    localparam logic [3:0] S_WRITE = 4'd3;
    localparam logic [3:0] S_PICK  = 4'd4;
    localparam logic [3:0] S_CNT   = 4'd5;
    localparam logic [3:0] S_UPD   = 4'd6;
    localparam logic [3:0] S_DONE  = 4'd7;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (st.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    case (s_op)
                        rdcw_pkg::OP_LOAD: begin
                            state_next = S_MOD;
                        end
                        rdcw_pkg::OP_QUERY: begin
                            state_next = S_PICK;
                        end
                        rdcw_pkg::OP_RESTART: begin
                            cmd.win_reset = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_MOD: begin
                cmd.mod_step = 1'b1;
                state_next   = S_WRITE;
            end
            S_WRITE: begin
                cmd.elem_write = 1'b1;
                state_next     = S_IDLE;
            end
            S_PICK: begin
                if (st.bad || (st.move == rdcw_pkg::MV_NONE)) begin
                    state_next = S_DONE;
                end else begin
                    cmd.step_start = 1'b1;
                    state_next     = S_CNT;
                end
            end
            S_CNT: begin
                cmd.cnt_read = 1'b1;
                state_next   = S_UPD;
            end
            S_UPD: begin
                cmd.cnt_update = 1'b1;
                state_next     = S_PICK;
            end
            S_DONE: begin
                if (st.out_free) begin
                    cmd.result_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

### sv/range_distinct_count_window_top.sv
`timescale 1ns / 1ps

// Distinct-value range counter over a sliding window. Each transfer carries an
// operation in s_tuser: load writes one array element (the value is reduced
// modulo VALUE_RANGE by a reciprocal multiply), restart empties the window and
// sweeps the occurrence-count memory to zero, and query returns the distinct
// count of positions left..right, walking the window edges from the previous
// query one position at a time; each position costs an element-memory read, a
// count-memory read and a count write-back. A reversed range leaves the window
// alone. A query also waits for as long as an earlier result is still held by
// m_tready. After reset the same count-memory sweep runs before the first item
// is taken. One item is worked on at a time; a finished result waits in an
// output register while the next item is taken.

module range_distinct_count_window_top #(
    parameter int ARRAY_DEPTH = rdcw_pkg::DEF_ARRAY_DEPTH,
    parameter int VALUE_RANGE = rdcw_pkg::DEF_VALUE_RANGE
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // index [9:0], value [19:10], left [29:20], right [39:30]
    input  logic [rdcw_pkg::S_DATA_W-1:0]    s_tdata,
    // operation [1:0]
    input  logic [rdcw_pkg::OP_W-1:0]        s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // distinct_count [10:0], zero fill [15:11]
    output logic [rdcw_pkg::M_DATA_W-1:0]    m_tdata,
    // status [0]
    output logic                             m_tuser
);

    rdcw_pkg::dp_cmd_t    cmd;
    rdcw_pkg::dp_status_t st;

    rdcw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tuser),
        .cmd      (cmd),
        .st       (st)
    );

    rdcw_datapath #(
        .ARRAY_DEPTH (ARRAY_DEPTH),
        .VALUE_RANGE (VALUE_RANGE)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .st       (st)
    );

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int POS_W        = rdcw_pkg::POS_W;
    localparam int CNT_W        = rdcw_pkg::CNT_W;
    localparam int OP_W         = rdcw_pkg::OP_W;
    localparam int S_DATA_W     = rdcw_pkg::S_DATA_W;
    localparam int M_DATA_W     = rdcw_pkg::M_DATA_W;
    localparam logic [OP_W-1:0] OP_LOAD    = rdcw_pkg::OP_LOAD;
    localparam logic [OP_W-1:0] OP_QUERY   = rdcw_pkg::OP_QUERY;
    localparam logic [OP_W-1:0] OP_RESTART = rdcw_pkg::OP_RESTART;
    localparam logic [OP_W-1:0] OP_NOP     = rdcw_pkg::OP_NOP;

    localparam int DEPTH        = rdcw_pkg::DEF_ARRAY_DEPTH;
    localparam int IDLE_LIMIT   = 20000;
    localparam int DRAIN_CYCLES = 1100;

    typedef struct {
        logic [CNT_W-1:0] count;
        logic             status;
    } answer_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    // index [9:0], value [19:10], left [29:20], right [39:30]
    logic [S_DATA_W-1:0] s_tdata  = '0;
    // operation [1:0]
    logic [OP_W-1:0]     s_tuser  = OP_NOP;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // distinct_count [10:0], zero fill [15:11]
    logic [M_DATA_W-1:0] m_tdata;
    // status [0]
    logic                m_tuser;

    range_distinct_count_window_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Shadow of the block: element array, per-value counts and the window.
    logic [POS_W-1:0] elem_mem  [DEPTH];
    logic [CNT_W-1:0] occ_count [DEPTH];
    logic [CNT_W-1:0] distinct_total;
    int               win_lo;
    int               win_hi;
    bit               written   [DEPTH];
    int               fill_len;

    answer_t pending_answers[$];

    int errors     = 0;
    int n_load     = 0;
    int n_query    = 0;
    int n_reject   = 0;
    int n_restart  = 0;
    int n_checked  = 0;
    int idle_count = 0;
    int stall_left = 0;
    bit no_idle    = 1'b0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic int clamp_pos(input int x, input int lo, input int hi);
        if (x < lo) return lo;
        if (x > hi) return hi;
        return x;
    endfunction

    function automatic void empty_window();
        foreach (occ_count[i]) occ_count[i] = '0;
        distinct_total = '0;
        win_lo = 0;
        win_hi = -1;
    endfunction

    function automatic void window_add(input int pos);
        logic [POS_W-1:0] v;
        v = elem_mem[pos[POS_W-1:0]];
        if (occ_count[v] == '0) distinct_total = distinct_total + 1'b1;
        occ_count[v] = occ_count[v] + 1'b1;
    endfunction

    function automatic void window_remove(input int pos);
        logic [POS_W-1:0] v;
        v = elem_mem[pos[POS_W-1:0]];
        occ_count[v] = occ_count[v] - 1'b1;
        if (occ_count[v] == '0) distinct_total = distinct_total - 1'b1;
    endfunction

    // Applies one accepted transfer to the shadow and queues the answer a query owes.
    function automatic void advance_window(input logic [OP_W-1:0] op,
                                           input logic [POS_W-1:0] idx, val, lf, rt);
        answer_t ans;
        int      lo;
        int      hi;
        case (op)
            OP_LOAD: begin
                elem_mem[idx] = val;
                written[idx] = 1'b1;
                while (fill_len < DEPTH && written[fill_len[POS_W-1:0]]) fill_len++;
                n_load++;
            end
            OP_RESTART: begin
                empty_window();
                n_restart++;
            end
            OP_QUERY: begin
                if (lf > rt) begin
                    ans.count = '0;
                    ans.status = 1'b1;
                    n_reject++;
                end else begin
                    lo = int'(lf);
                    hi = int'(rt);
                    while (win_lo > lo) begin
                        win_lo--;
                        window_add(win_lo);
                    end
                    while (win_hi < hi) begin
                        win_hi++;
                        window_add(win_hi);
                    end
                    while (win_lo < lo) begin
                        window_remove(win_lo);
                        win_lo++;
                    end
                    while (win_hi > hi) begin
                        window_remove(win_hi);
                        win_hi--;
                    end
                    ans.count = distinct_total;
                    ans.status = 1'b0;
                    n_query++;
                end
                pending_answers = {pending_answers, ans};
            end
            default: ;
        endcase
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] idx, val, lf, rt);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {rt, lf, val, idx};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        advance_window(op, idx, val, lf, rt);
    endtask

    // Holds the sender off until every owed answer has come back.
    task automatic settle_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        send_item(OP_LOAD, 10'd0, 10'd0, 10'd0, 10'd0);
        send_item(OP_LOAD, 10'd1, 10'd1023, 10'd0, 10'd0);
        send_item(OP_LOAD, 10'd2, 10'd5, 10'd0, 10'd0);
        send_item(OP_LOAD, 10'd3, 10'd5, 10'd0, 10'd0);
        send_item(OP_LOAD, 10'd4, 10'd1023, 10'd0, 10'd0);
        send_item(OP_LOAD, 10'd5, 10'd7, 10'd0, 10'd0);
        send_item(OP_LOAD, 10'd6, 10'd0, 10'd0, 10'd0);
        send_item(OP_LOAD, 10'd7, 10'd9, 10'd0, 10'd0);
        send_item(OP_LOAD, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
        send_item(OP_QUERY, 10'd0, 10'd0, 10'd0, 10'd0);
        send_item(OP_QUERY, 10'd0, 10'd0, 10'd0, 10'd7);
        send_item(OP_QUERY, 10'd0, 10'd0, 10'd3, 10'd5);
        send_item(OP_QUERY, 10'd0, 10'd0, 10'd1, 10'd7);
        send_item(OP_QUERY, 10'd0, 10'd0, 10'd7, 10'd7);
        // Reversed ranges must leave the window alone.
        send_item(OP_QUERY, 10'd0, 10'd0, 10'd1023, 10'd0);
        send_item(OP_QUERY, 10'd0, 10'd0, 10'd5, 10'd4);
        send_item(OP_QUERY, 10'd0, 10'd0, 10'd1023, 10'd1022);
        send_item(OP_RESTART, 10'd0, 10'd0, 10'd0, 10'd0);
        send_item(OP_QUERY, 10'd0, 10'd0, 10'd2, 10'd6);
        send_item(OP_NOP, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
        // Overwriting a position inside the window leaves the counts stale, and
        // dropping it later wraps the count of the new value below zero.
        send_item(OP_LOAD, 10'd3, 10'd900, 10'd0, 10'd0);
        send_item(OP_QUERY, 10'd0, 10'd0, 10'd4, 10'd6);
        send_item(OP_QUERY, 10'd0, 10'd0, 10'd0, 10'd7);
    endtask

    task automatic test_random_traffic(input int n);
        int               sent;
        int               r;
        int               lo;
        int               hi;
        logic [POS_W-1:0] idx;
        logic [POS_W-1:0] val;
        sent = 0;
        while (sent < n) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                r = $urandom_range(0, 99);
                if (r < 40 && fill_len < DEPTH) idx = fill_len[POS_W-1:0];
                else if (r < 85)
                    idx = POS_W'($urandom_range(0, clamp_pos(fill_len + 4, 0, DEPTH - 1)));
                else idx = POS_W'($urandom_range(0, DEPTH - 1));
                val = ($urandom_range(0, 99) < 60) ? POS_W'($urandom_range(0, 15)) :
                                                     POS_W'($urandom_range(0, 1023));
                send_item(OP_LOAD, idx, val, POS_W'($urandom), POS_W'($urandom));
                sent++;
            end else if (r < 88) begin
                if (fill_len == 0 || $urandom_range(0, 99) < 12) begin
                    lo = $urandom_range(1, DEPTH - 1);
                    hi = $urandom_range(0, lo - 1);
                end else if (win_hi >= 0 && $urandom_range(0, 99) < 70) begin
                    // Stay near the current window so most queries move it a little.
                    hi = clamp_pos(win_hi + int'($urandom_range(0, 32)) - 16, 0, fill_len - 1);
                    lo = clamp_pos(win_lo + int'($urandom_range(0, 32)) - 16, 0, hi);
                end else begin
                    hi = $urandom_range(0, fill_len - 1);
                    lo = ($urandom_range(0, 9) == 0) ? hi : $urandom_range(0, hi);
                end
                send_item(OP_QUERY, POS_W'($urandom), POS_W'($urandom),
                          lo[POS_W-1:0], hi[POS_W-1:0]);
                sent++;
            end else if (r < 91) begin
                send_item(OP_RESTART, POS_W'($urandom), POS_W'($urandom),
                          POS_W'($urandom), POS_W'($urandom));
                sent++;
            end else begin
                send_item(OP_NOP, POS_W'($urandom), POS_W'($urandom),
                          POS_W'($urandom), POS_W'($urandom));
            end
        end
    endtask

    task automatic test_back_to_back(input int n);
        no_idle = 1'b1;
        test_random_traffic(n);
        no_idle = 1'b0;
    endtask

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (no_idle || $urandom_range(0, 99) < 65) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= 1'b0;
            stall_left = pick_gap();
        end
    end

    always @(posedge aclk) begin
        answer_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("transfer with no query pending, count",
                                int'(m_tdata[CNT_W-1:0]), 0);
            end else begin
                want = pending_answers.pop_front();
                n_checked++;
                if (m_tdata[CNT_W-1:0] !== want.count)
                    report_mismatch("distinct_count", int'(m_tdata[CNT_W-1:0]),
                                    int'(want.count));
                if (m_tuser !== want.status)
                    report_mismatch("status", int'(m_tuser), int'(want.status));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_count = 0;
        end else begin
            idle_count++;
            if (idle_count >= IDLE_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
                $display("[range_distinct_count_window_top] ERROR");
                $finish;
            end
        end
    end

    initial begin
        empty_window();
        fill_len = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        settle_results();
        test_random_traffic(560);
        settle_results();
        test_back_to_back(180);
        settle_results();
        test_random_traffic(560);
        settle_results();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_answers.size() != 0)
            report_mismatch("answers still owed at end", 0, pending_answers.size());

        $display("Run covered %0d loads, %0d range queries, %0d reversed ranges, %0d restarts.",
                 n_load, n_query, n_reject, n_restart);
        $display("%0d answers compared; array filled from position 0 up to %0d.",
                 n_checked, fill_len);
        if (errors == 0) begin
            $display("[range_distinct_count_window_top] OK");
        end else begin
            $display("[range_distinct_count_window_top] ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
sv/rdcw_pkg.sv
sv/rdcw_datapath.sv
sv/rdcw_ctrl.sv
sv/range_distinct_count_window_top.sv
dv/tb_top.sv
